>>> src/spt_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and default constants for the sorted point table
// no dependencies; used by every module under src

package spt_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 10;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int RES_W     = 3;
  localparam int RAD_W     = 6;
  localparam int IDX_OUT_W = 8;
  localparam int CNT_OUT_W = 9;

  // widest values the parameters can reach, used by shared structs
  localparam int IDX_MAX_W   = 12;
  localparam int COORD_MAX_W = 16;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd5;

  // latency of the distance unit, in cycles
  localparam int DIST_LAT = 2;

  localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  typedef enum logic [RES_W-1:0] {
    RES_NOTHING  = 3'd0,
    RES_GRABBED  = 3'd1,
    RES_INSERTED = 3'd2,
    RES_MOVED    = 3'd3,
    RES_RELEASED = 3'd4,
    RES_FULL     = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_WRITE  = 2'd3
  } cell_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_MAX_W-1:0]   idx;
    logic [COORD_MAX_W-1:0] x;
    logic [COORD_MAX_W-1:0] y;
  } cell_cmd_t;

  // per-entry answer from the distance unit
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 gt;
    logic [IDX_MAX_W-1:0] idx;
  } dist_res_t;

endpackage

>>> src/spt_cell.sv
`timescale 1ns / 1ps
// one entry of the point chain: holds x and y, rotates, shifts or is overwritten
// depends on spt_pkg

module spt_cell #(
  parameter int COORD_BITS = spt_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 8,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  spt_pkg::cell_cmd_t    cmd,
  input  logic [COORD_BITS-1:0] up_x,
  input  logic [COORD_BITS-1:0] up_y,
  input  logic [COORD_BITS-1:0] dn_x,
  input  logic [COORD_BITS-1:0] dn_y,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);
  import spt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [IDX_W-1:0]      cmd_idx;
  logic [COORD_BITS-1:0] x_next;
  logic [COORD_BITS-1:0] y_next;

  assign cmd_idx = cmd.idx[IDX_W-1:0];

  always_comb begin
    x_next = x;
    y_next = y;
    case (cmd.op)
      OP_ROTATE: begin
        x_next = up_x;
        y_next = up_y;
      end
      OP_INSERT: begin
        // entries above the insert point move up by one
        if (MY_IDX > cmd_idx) begin
          x_next = dn_x;
          y_next = dn_y;
        end else if (MY_IDX == cmd_idx) begin
          x_next = cmd.x[COORD_BITS-1:0];
          y_next = cmd.y[COORD_BITS-1:0];
        end
      end
      OP_WRITE: begin
        if (MY_IDX == cmd_idx) begin
          x_next = cmd.x[COORD_BITS-1:0];
          y_next = cmd.y[COORD_BITS-1:0];
        end
      end
      default: begin
        x_next = x;
        y_next = y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
  end

endmodule

>>> src/spt_dist.sv
`timescale 1ns / 1ps
// two-stage squared distance and x order test on the entry at the chain head
// depends on spt_pkg

module spt_dist #(
  parameter int COORD_BITS = spt_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [IDX_W-1:0]          idx,
  input  logic [COORD_BITS-1:0]     ent_x,
  input  logic [COORD_BITS-1:0]     ent_y,
  input  logic [COORD_BITS-1:0]     px,
  input  logic [COORD_BITS-1:0]     py,
  input  logic [spt_pkg::RAD_W-1:0] radius,
  output spt_pkg::dist_res_t        res
);
  import spt_pkg::*;

  localparam int SQW  = 2 * COORD_BITS;
  localparam int R2W  = 2 * RAD_W;
  localparam int SUMW = (SQW + 1 > R2W) ? SQW + 1 : R2W;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  logic                  v1;
  logic [SQW-1:0]        sqx;
  logic [SQW-1:0]        sqy;
  logic [R2W-1:0]        r2;
  logic                  gt1;
  logic [IDX_W-1:0]      idx1;
  logic [SUMW-1:0]       dist2;

  assign dx = (ent_x >= px) ? ent_x - px : px - ent_x;
  assign dy = (ent_y >= py) ? ent_y - py : py - ent_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= en;
    end
  end

  always_ff @(posedge clk) begin
    sqx  <= SQW'(dx) * SQW'(dx);
    sqy  <= SQW'(dy) * SQW'(dy);
    r2   <= R2W'(radius) * R2W'(radius);
    gt1  <= px < ent_x;
    idx1 <= idx;
  end

  assign dist2 = SUMW'(sqx) + SUMW'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= v1;
    end
    res.hit <= dist2 < SUMW'(r2);
    res.gt  <= gt1;
    res.idx <= IDX_MAX_W'(idx1);
  end

endmodule

>>> src/sorted_point_table_with_hit_test.sv
`timescale 1ns / 1ps
// sorted point table with pointer hit test: controller and the chain of entry cells
// depends on spt_pkg, spt_cell, spt_dist
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------------
//  in      | into      | in_valid / in_stall  | req_type, pos_x, pos_y
//  out     | out of    | out_valid / out_stall| event_result, entry_index, point_count,
//          |           |                      | drag_active
//  cfg     | into      | cfg_wr_en            | cfg_wr_data (hit radius)
//
// a press is accepted, scanned while the ring turns once past the distance unit, then decided
// move, release and unknown words go straight from accept to decide
// in_stall is high from accept until the result is loaded into the output register
// the output register is loaded only when empty or being taken; a stalled output
// holds the decide cycle, a new word is accepted while the result waits
// rst clears control state and sets the radius to RADIUS_RESET; entry contents are not cleared

module sorted_point_table_with_hit_test #(
  parameter int MAX_POINTS = spt_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = spt_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spt_pkg::REQ_W-1:0]     req_type,
  input  logic [COORD_BITS-1:0]         pos_x,
  input  logic [COORD_BITS-1:0]         pos_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spt_pkg::RES_W-1:0]     event_result,
  output logic [spt_pkg::IDX_OUT_W-1:0] entry_index,
  output logic [spt_pkg::CNT_OUT_W-1:0] point_count,
  output logic                          drag_active,
  input  logic                          cfg_wr_en,
  input  logic [spt_pkg::RAD_W-1:0]     cfg_wr_data
);
  import spt_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int SCW   = $clog2(MAX_POINTS + DIST_LAT);
  localparam logic [SCW-1:0]  SCAN_LAST = SCW'(MAX_POINTS + DIST_LAT - 1);
  localparam logic [SCW-1:0]  SCAN_ROT  = SCW'(MAX_POINTS);
  localparam logic [CNTW-1:0] CNT_FULL  = CNTW'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t                st;
  state_t                st_next;
  logic [REQ_W-1:0]      req_kind;
  logic [COORD_BITS-1:0] req_x;
  logic [COORD_BITS-1:0] req_y;
  logic [SCW-1:0]        scan_cnt;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic                  gt_found;
  logic [IDX_W-1:0]      gt_idx;
  logic [CNTW-1:0]       count;
  logic [CNTW-1:0]       count_next;
  logic                  dragging;
  logic                  dragging_next;
  logic [IDX_W-1:0]      drag_slot;
  logic [IDX_W-1:0]      drag_slot_next;
  logic [RAD_W-1:0]      radius;

  logic                  in_fire;
  logic                  fire;
  logic                  feed;
  res_t                  res_code;
  logic [IDX_W-1:0]      res_idx;
  logic [IDX_W-1:0]      ins_pos;
  cell_cmd_t             cmd;
  dist_res_t             dres;

  logic [COORD_BITS-1:0] cell_x [MAX_POINTS];
  logic [COORD_BITS-1:0] cell_y [MAX_POINTS];

  assign in_stall = (st != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fire     = (st == ST_DECIDE) && (!out_valid || !out_stall);
  assign feed     = (st == ST_SCAN) && (scan_cnt < SCW'(count));
  assign ins_pos  = gt_found ? gt_idx : count[IDX_W-1:0];

  // the chain of entry cells, closed into a ring for the scan rotation
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int UP = (i == MAX_POINTS - 1) ? 0 : i + 1;
    localparam int DN = (i == 0) ? 0 : i - 1;
    spt_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .up_x (cell_x[UP]),
      .up_y (cell_y[UP]),
      .dn_x (cell_x[DN]),
      .dn_y (cell_y[DN]),
      .x    (cell_x[i]),
      .y    (cell_y[i])
    );
  end

  spt_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .en     (feed),
    .idx    (scan_cnt[IDX_W-1:0]),
    .ent_x  (cell_x[0]),
    .ent_y  (cell_y[0]),
    .px     (req_x),
    .py     (req_y),
    .radius (radius),
    .res    (dres)
  );

  // decide the outcome of the held word
  always_comb begin
    res_code       = RES_NOTHING;
    res_idx        = '0;
    count_next     = count;
    dragging_next  = dragging;
    drag_slot_next = drag_slot;
    case (req_kind)
      REQ_PRESS: begin
        if (hit_found) begin
          res_code       = RES_GRABBED;
          res_idx        = hit_idx;
          dragging_next  = 1'b1;
          drag_slot_next = hit_idx;
        end else if (count == CNT_FULL) begin
          res_code = RES_FULL;
        end else begin
          res_code   = RES_INSERTED;
          res_idx    = ins_pos;
          count_next = count + 1'b1;
        end
      end
      REQ_MOVE: begin
        if (dragging) begin
          res_code = RES_MOVED;
          res_idx  = drag_slot;
        end
      end
      REQ_RELEASE: begin
        if (dragging) begin
          res_code      = RES_RELEASED;
          dragging_next = 1'b0;
        end
      end
      default: begin
        res_code = RES_NOTHING;
      end
    endcase
  end

  always_comb begin
    cmd.op  = OP_HOLD;
    cmd.idx = '0;
    cmd.x   = COORD_MAX_W'(req_x);
    cmd.y   = COORD_MAX_W'(req_y);
    if (st == ST_SCAN && scan_cnt < SCAN_ROT) begin
      cmd.op = OP_ROTATE;
    end else if (fire && res_code == RES_INSERTED) begin
      cmd.op  = OP_INSERT;
      cmd.idx = IDX_MAX_W'(ins_pos);
    end else if (fire && res_code == RES_MOVED) begin
      cmd.op  = OP_WRITE;
      cmd.idx = IDX_MAX_W'(drag_slot);
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_fire) begin
          st_next = (req_type == REQ_PRESS) ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_LAST) begin
          st_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (fire) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      scan_cnt  <= '0;
      hit_found <= 1'b0;
      gt_found  <= 1'b0;
      count     <= '0;
      dragging  <= 1'b0;
      drag_slot <= '0;
      radius    <= RADIUS_RESET;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_wr_en) begin
        radius <= cfg_wr_data;
      end
      if (in_fire) begin
        scan_cnt  <= '0;
        hit_found <= 1'b0;
        gt_found  <= 1'b0;
      end else if (st == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        // keep only the first hit and the first larger x
        if (dres.valid && dres.hit && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (dres.valid && dres.gt && !gt_found) begin
          gt_found <= 1'b1;
        end
      end
      if (fire) begin
        count     <= count_next;
        dragging  <= dragging_next;
        drag_slot <= drag_slot_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind <= req_type;
      req_x    <= pos_x;
      req_y    <= pos_y;
    end
    if (dres.valid && dres.hit && !hit_found) begin
      hit_idx <= dres.idx[IDX_W-1:0];
    end
    if (dres.valid && dres.gt && !gt_found) begin
      gt_idx <= dres.idx[IDX_W-1:0];
    end
    if (fire) begin
      event_result <= res_code;
      entry_index  <= IDX_OUT_W'(res_idx);
      point_count  <= CNT_OUT_W'(count_next);
      drag_active  <= dragging_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("point count above table size");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_drag_in_range: assert property (@(posedge clk) disable iff (rst)
    dragging |-> CNTW'(drag_slot) < count)
    else $error("drag slot outside stored entries");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dres.valid |-> st == ST_SCAN)
    else $error("distance answer outside scan");

  a_no_rotate_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ROTATE) |-> (st == ST_SCAN && !fire))
    else $error("ring rotated outside scan");

endmodule
